// File: rtl/core/watchdog_down_counter_core_defines.svh
// Assertion helpers shared by the watchdog core modules.
// Each expects clk and rst to be visible in the module that uses it.
`ifndef WATCHDOG_DOWN_COUNTER_CORE_DEFINES_SVH
`define WATCHDOG_DOWN_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wdc_pkg.sv
`default_nettype none
package wdc_pkg;

  localparam int DATA_W           = 32;
  localparam int CTL_W            = 17;
  localparam int DIV_W            = 7;
  localparam int COUNTER_WIDTH_D  = 32;
  localparam int PRESCALE_WIDTH_D = 8;

  localparam int CTL_RSTEN_BIT  = 0;
  localparam int CTL_INTEN_BIT  = 2;
  localparam int CTL_CLKSEL_LSB = 3;
  localparam int CTL_ENABLE_BIT = 5;
  localparam int CTL_PRE_LSB    = 8;

  localparam logic [DATA_W-1:0] CNT_RESET_VAL = 32'h0000_8000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_CTRL   = 2'd0,
    REG_RELOAD = 2'd1,
    REG_COUNT  = 2'd2,
    REG_CLRINT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CFG_GATE   = 1'b0,
    CFG_UNMASK = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        reg_index;
    logic [DATA_W-1:0] write_value;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              irq_out;
    logic              system_reset;
  } out_beat_t;

  // Divider terminal count by clock select: 15, 31, 63 or 127.
  function automatic logic [DIV_W-1:0] div_limit(input logic [1:0] sel);
    logic [DIV_W-1:0] lim;
    unique case (sel)
      2'd0:    lim = 7'd15;
      2'd1:    lim = 7'd31;
      2'd2:    lim = 7'd63;
      default: lim = 7'd127;
    endcase
    return lim;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/watchdog_down_counter_core.sv
// An accepted beat waits in the input register until the output register is free; a
// single-pass update then writes its result to the output register, which drives out_valid.
// Throughput: one beat per cycle while the output is not stalled.
// Reset (rst, synchronous, active high) clears both stages, the config gates, the
// control word, counters and flags; reload and count return to 0x8000.
`default_nettype none
module watchdog_down_counter_core
  import wdc_pkg::*;
#(
  parameter int COUNTER_WIDTH  = COUNTER_WIDTH_D,
  parameter int PRESCALE_WIDTH = PRESCALE_WIDTH_D
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic      cfg_data,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_beat
);

  logic      out_free;
  logic      fire;
  in_beat_t  item;
  out_beat_t res;
  logic      out_stall;

  assign out_stall = out_valid && !out_ready;

  wdc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_free (out_free),
    .fire     (fire),
    .item     (item)
  );

  wdc_engine #(
    .COUNTER_WIDTH  (COUNTER_WIDTH),
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  wdc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

`include "watchdog_down_counter_core_defines.svh"

  `WDC_ASSERT_IMP(a_stall_backs_up, out_stall && !in_ready, !fire, "beat advanced into full output")
  `WDC_ASSERT_NXT(a_fire_fills_out, fire, out_valid, "result lost after advance")

endmodule
`default_nettype wire

// File: rtl/core/wdc_in_stage.sv
`default_nettype none
module wdc_in_stage
  import wdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_beat,
  input  wire logic     out_free,
  output logic          fire,
  output in_beat_t      item
);

  logic     valid;
  in_beat_t beat;

  assign fire     = valid && out_free;
  assign in_ready = !valid || out_free;
  assign item     = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= in_beat;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/wdc_engine.sv
`default_nettype none
module wdc_engine
  import wdc_pkg::*;
#(
  parameter int COUNTER_WIDTH  = COUNTER_WIDTH_D,
  parameter int PRESCALE_WIDTH = PRESCALE_WIDTH_D
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic     cfg_index,
  input  wire logic     cfg_data,
  input  wire logic     fire,
  input  wire in_beat_t item,
  output out_beat_t     res
);

  localparam int CW = COUNTER_WIDTH;
  localparam int PW = PRESCALE_WIDTH;

  logic             gate_en;
  logic             rst_unmask;
  logic [CTL_W-1:0] ctl,           ctl_next;
  logic [CW-1:0]    reload,        reload_next;
  logic [CW-1:0]    count,         count_next;
  logic [PW-1:0]    pre_cnt,       pre_cnt_next;
  logic [DIV_W-1:0] div_cnt,       div_cnt_next;
  logic             irq_pending,   irq_pending_next;
  logic             reset_latched, reset_latched_next;

  logic [PW-1:0]     pre_lim;
  logic [DIV_W-1:0]  div_lim;
  logic              running;
  logic              step;
  logic [DATA_W-1:0] rd;
  action_t           act;
  reg_idx_t          ridx;
  logic              clr_int;

  assign act     = action_t'(item.action);
  assign ridx    = reg_idx_t'(item.reg_index);
  assign pre_lim = ctl[CTL_PRE_LSB +: PW];
  assign div_lim = div_limit(ctl[CTL_CLKSEL_LSB +: 2]);
  assign running = ctl[CTL_ENABLE_BIT] && gate_en;
  // Counter steps when both prescaler and divider wrap on this tick.
  assign step    = running && (pre_cnt >= pre_lim) && (div_cnt >= div_lim);
  assign clr_int = fire && act == ACT_WRITE && ridx == REG_CLRINT;

  always_comb begin
    ctl_next           = ctl;
    reload_next        = reload;
    count_next         = count;
    pre_cnt_next       = pre_cnt;
    div_cnt_next       = div_cnt;
    irq_pending_next   = irq_pending;
    reset_latched_next = reset_latched;
    rd                 = '0;
    unique case (act)
      ACT_TICK: begin
        if (running) begin
          if (pre_cnt >= pre_lim) begin
            pre_cnt_next = '0;
            if (div_cnt >= div_lim) begin
              div_cnt_next = '0;
            end else begin
              div_cnt_next = div_cnt + DIV_W'(1);
            end
          end else begin
            pre_cnt_next = pre_cnt + PW'(1);
          end
        end
        if (step) begin
          // One or zero both count as reaching zero.
          if (count <= CW'(1)) begin
            count_next = reload;
            if (ctl[CTL_INTEN_BIT]) begin
              irq_pending_next = 1'b1;
            end
            if (ctl[CTL_RSTEN_BIT] && rst_unmask) begin
              reset_latched_next = 1'b1;
            end
          end else begin
            count_next = count - CW'(1);
          end
        end
      end
      ACT_READ: begin
        unique case (ridx)
          REG_CTRL:   rd = DATA_W'(ctl);
          REG_RELOAD: rd = DATA_W'(reload);
          REG_COUNT:  rd = DATA_W'(count);
          REG_CLRINT: rd = '0;
        endcase
      end
      ACT_WRITE: begin
        unique case (ridx)
          REG_CTRL: begin
            ctl_next     = item.write_value[CTL_W-1:0];
            pre_cnt_next = '0;
            div_cnt_next = '0;
          end
          REG_RELOAD: reload_next      = item.write_value[CW-1:0];
          REG_COUNT:  count_next       = item.write_value[CW-1:0];
          REG_CLRINT: irq_pending_next = 1'b0;
        endcase
      end
      default: begin
        // unused action: hold everything
      end
    endcase
  end

  assign res.read_value   = rd;
  assign res.irq_out      = irq_pending_next;
  assign res.system_reset = reset_latched_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_en    <= 1'b0;
      rst_unmask <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GATE:   gate_en    <= cfg_data;
        CFG_UNMASK: rst_unmask <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl           <= '0;
      reload        <= CNT_RESET_VAL[CW-1:0];
      count         <= CNT_RESET_VAL[CW-1:0];
      pre_cnt       <= '0;
      div_cnt       <= '0;
      irq_pending   <= 1'b0;
      reset_latched <= 1'b0;
    end else if (fire) begin
      ctl           <= ctl_next;
      reload        <= reload_next;
      count         <= count_next;
      pre_cnt       <= pre_cnt_next;
      div_cnt       <= div_cnt_next;
      irq_pending   <= irq_pending_next;
      reset_latched <= reset_latched_next;
    end
  end

`include "watchdog_down_counter_core_defines.svh"

  `WDC_ASSERT_NXT(a_reset_sticky, reset_latched, reset_latched, "reset latch dropped")
  `WDC_ASSERT_NXT(a_clr_irq, clr_int, !irq_pending, "irq not cleared")
  `WDC_ASSERT_IMP(a_pre_bound, 1'b1, pre_cnt <= pre_lim, "prescaler past limit")
  `WDC_ASSERT_IMP(a_div_bound, 1'b1, div_cnt <= div_lim, "divider past limit")

endmodule
`default_nettype wire

// File: rtl/core/wdc_out_stage.sv
`default_nettype none
module wdc_out_stage
  import wdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_beat_t res,
  output logic           out_free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_beat
);

  logic      valid;
  out_beat_t beat;

  assign out_free  = !valid || out_ready;
  assign out_valid = valid;
  assign out_beat  = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= res;
    end
  end

endmodule
`default_nettype wire

// File: dv/watchdog_down_counter_core_test.sv
`default_nettype none
module watchdog_down_counter_core_test;
  import wdc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;
  logic in_valid;
  logic in_ready;
  in_beat_t in_beat;
  logic out_valid;
  logic out_ready;
  out_beat_t out_beat;

  // Shadow copy of the watchdog state.
  logic [CTL_W-1:0]  wd_ctl;
  logic [31:0]       wd_reload;
  logic [31:0]       wd_count;
  logic [7:0]        wd_pre;
  logic [DIV_W-1:0]  wd_div;
  logic              wd_irq;
  logic              wd_rst_req;
  logic              wd_gate;
  logic              wd_unmask;

  out_beat_t pending_status[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  logic no_idle = 1'b0;

  watchdog_down_counter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Advance the down-counter by one divided tick.
  task automatic count_down_step();
    if (wd_count <= 32'd1) begin
      wd_count = wd_reload;
      if (wd_ctl[CTL_INTEN_BIT]) wd_irq = 1'b1;
      if (wd_ctl[CTL_RSTEN_BIT] && wd_unmask) wd_rst_req = 1'b1;
    end else begin
      wd_count = wd_count - 32'd1;
    end
  endtask

  task automatic watchdog_advance(input in_beat_t b, output out_beat_t r);
    logic [31:0] rd;
    logic [7:0] pre_lim;
    logic [DIV_W-1:0] div_lim;
    rd = '0;
    case (b.action)
      ACT_TICK: begin
        if (wd_ctl[CTL_ENABLE_BIT] && wd_gate) begin
          pre_lim = wd_ctl[CTL_PRE_LSB +: 8];
          if (wd_pre >= pre_lim) begin
            wd_pre = '0;
            div_lim = DIV_W'((16 << wd_ctl[CTL_CLKSEL_LSB +: 2]) - 1);
            if (wd_div >= div_lim) begin
              wd_div = '0;
              count_down_step();
            end else begin
              wd_div = wd_div + 7'd1;
            end
          end else begin
            wd_pre = wd_pre + 8'd1;
          end
        end
      end
      ACT_READ: begin
        case (b.reg_index)
          REG_CTRL:   rd = 32'(wd_ctl);
          REG_RELOAD: rd = wd_reload;
          REG_COUNT:  rd = wd_count;
          default:    rd = '0;
        endcase
      end
      ACT_WRITE: begin
        case (b.reg_index)
          REG_CTRL: begin
            wd_ctl = b.write_value[CTL_W-1:0];
            wd_pre = '0;
            wd_div = '0;
          end
          REG_RELOAD: wd_reload = b.write_value;
          REG_COUNT:  wd_count = b.write_value;
          default:    wd_irq = 1'b0;
        endcase
      end
      default: ;
    endcase
    r.read_value = rd;
    r.irq_out = wd_irq;
    r.system_reset = wd_rst_req;
  endtask

  task automatic send_beat(input logic [1:0] act, input logic [1:0] idx,
                           input logic [31:0] data);
    in_beat_t b;
    out_beat_t want;
    int gap;
    b.action = act;
    b.reg_index = idx;
    b.write_value = data;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (!in_ready);
    watchdog_advance(b, want);
    pending_status.push_back(want);
  endtask

  // Hold input until every outstanding beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gates(input logic gate, input logic unmask);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_GATE;
    cfg_data <= gate;
    @(posedge clk);
    cfg_index <= CFG_UNMASK;
    cfg_data <= unmask;
    @(posedge clk);
    cfg_we <= 1'b0;
    wd_gate = gate;
    wd_unmask = unmask;
  endtask

  // Receive side: hold out_ready low for a random stall before each beat.
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, out_beat);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        if (out_beat.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   want.read_value, out_beat.read_value);
          mismatch_count++;
        end
        if (out_beat.irq_out !== want.irq_out) begin
          $display("%0t: irq_out expected %b actual %b", $time,
                   want.irq_out, out_beat.irq_out);
          mismatch_count++;
        end
        if (out_beat.system_reset !== want.system_reset) begin
          $display("%0t: system_reset expected %b actual %b", $time,
                   want.system_reset, out_beat.system_reset);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_beat(ACT_READ, REG_CTRL, '0);
    send_beat(ACT_READ, REG_RELOAD, '0);
    send_beat(ACT_READ, REG_COUNT, '0);
    send_beat(ACT_READ, REG_CLRINT, 32'hffff_ffff);
    send_beat(ACT_TICK, REG_CTRL, 32'hffff_ffff);
    send_beat(ACT_UNUSED, REG_CLRINT, 32'hffff_ffff);
  endtask

  task automatic test_register_access();
    send_beat(ACT_WRITE, REG_CTRL, 32'hffff_ffff);
    send_beat(ACT_READ, REG_CTRL, '0);
    send_beat(ACT_WRITE, REG_RELOAD, 32'hffff_ffff);
    send_beat(ACT_READ, REG_RELOAD, '0);
    send_beat(ACT_WRITE, REG_COUNT, '0);
    send_beat(ACT_READ, REG_COUNT, '0);
    send_beat(ACT_WRITE, REG_COUNT, 32'hffff_ffff);
    send_beat(ACT_READ, REG_COUNT, '0);
    send_beat(ACT_UNUSED, REG_COUNT, '0);
    send_beat(ACT_WRITE, REG_CLRINT, 32'h0);
    send_beat(ACT_WRITE, REG_CTRL, '0);
  endtask

  // Counter at one with a zero reload: every divided tick underflows.
  task automatic test_underflow();
    logic [31:0] ctl;
    set_gates(1'b1, 1'b0);
    ctl = '0;
    ctl[CTL_ENABLE_BIT] = 1'b1;
    ctl[CTL_INTEN_BIT] = 1'b1;
    send_beat(ACT_WRITE, REG_RELOAD, '0);
    send_beat(ACT_WRITE, REG_COUNT, 32'd1);
    send_beat(ACT_WRITE, REG_CTRL, ctl);
    repeat (16) send_beat(ACT_TICK, REG_CTRL, $urandom());
    send_beat(ACT_READ, REG_COUNT, '0);
    send_beat(ACT_WRITE, REG_CLRINT, 32'hffff_ffff);
  endtask

  task automatic send_random_beat();
    int pick;
    logic [31:0] data;
    logic [1:0] idx;
    pick = $urandom_range(0, 99);
    data = $urandom();
    idx = 2'($urandom_range(0, 3));
    if (pick < 78) begin
      send_beat(ACT_TICK, idx, data);
    end else if (pick < 86) begin
      send_beat(ACT_READ, idx, data);
    end else if (pick < 88) begin
      // Mostly a running, fast setup so the counter reaches zero often.
      if ($urandom_range(0, 4) != 0) begin
        data[CTL_ENABLE_BIT] = 1'b1;
        data[CTL_PRE_LSB +: 8] = 8'($urandom_range(0, 2));
        if ($urandom_range(0, 2) != 0) data[CTL_CLKSEL_LSB +: 2] = 2'd0;
      end
      send_beat(ACT_WRITE, REG_CTRL, data);
    end else if (pick < 94) begin
      if ($urandom_range(0, 4) != 0) data = $urandom_range(0, 6);
      send_beat(ACT_WRITE, (pick < 91) ? REG_RELOAD : REG_COUNT, data);
    end else if (pick < 98) begin
      send_beat(ACT_WRITE, REG_CLRINT, data);
    end else begin
      send_beat(ACT_UNUSED, idx, data);
    end
  endtask

  task automatic test_random_traffic(input logic gate, input logic unmask,
                                     input int n_items);
    set_gates(gate, unmask);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 250 == 249) drain_results();
      send_random_beat();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    in_beat <= '0;
    wd_ctl = '0;
    wd_reload = CNT_RESET_VAL;
    wd_count = CNT_RESET_VAL;
    wd_pre = '0;
    wd_div = '0;
    wd_irq = 1'b0;
    wd_rst_req = 1'b0;
    wd_gate = 1'b0;
    wd_unmask = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_register_access();
    test_underflow();
    test_random_traffic(1'b1, 1'b0, 400);
    test_random_traffic(1'b0, 1'b0, 100);
    test_random_traffic(1'b0, 1'b1, 100);
    test_random_traffic(1'b1, 1'b0, 350);
    // Reset request is sticky, so run the phase with gate and unmask both set last.
    test_random_traffic(1'b1, 1'b1, 200);
    drain_results();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
